// ===== rtl/sha256_stream_hasher_macros.svh =====
// assertion macros shared by the sha256 stream hasher modules
// no dependencies; included inside module bodies
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH

// same-cycle implication, checked outside reset
`define SHA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SHA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sha256_pkg.sv =====
// shared types, constants and round functions of the sha256 stream hasher
// no dependencies; imported by sha256_ctrl, sha256_dp and the top level
package sha256_pkg;

    localparam int BLK_BYTES = 64;
    localparam int BLK_BITS  = BLK_BYTES * 8;
    localparam int POS_W     = $clog2(BLK_BYTES);
    localparam int ROUNDS    = 64;
    localparam int ROUND_W   = $clog2(ROUNDS);
    localparam int WORDS     = 8;
    localparam int WIDX_W    = $clog2(WORDS);
    localparam int COUNT_W   = 61;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [31:0] K_TABLE [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] IV_TABLE [WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // controller to datapath
    typedef struct packed {
        logic                 load_in;
        logic                 load_pad;
        logic                 start;
        logic                 round;
        logic                 finish;
        logic                 emit;
        logic                 clear;
        logic [ROUND_W-1:0]   round_idx;
        logic [WIDX_W-1:0]    word_idx;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic pos_last;
        logic final_blk;
        logic out_free;
    } t_sts;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] sml_sig0(input logic [31:0] x);
        sml_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sml_sig1(input logic [31:0] x);
        sml_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ===== rtl/sha256_ctrl.sv =====
// controller of the sha256 stream hasher: input handshake, padding, round and output sequencing
// depends on sha256_pkg and sha256_stream_hasher_macros.svh
module sha256_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_has_byte,
    input  logic              i_is_last,
    output logic              o_in_stall,
    input  sha256_pkg::t_sts  i_sts,
    output sha256_pkg::t_cmd  o_cmd
);
    import sha256_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_COMP = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(ROUNDS - 1);
    localparam logic [WIDX_W-1:0]  WIDX_LAST  = WIDX_W'(WORDS - 1);

    logic [2:0]         r_state, n_state;
    logic [ROUND_W-1:0] r_round, n_round;
    logic [WIDX_W-1:0]  r_widx, n_widx;
    logic               r_closing, n_closing;
    logic               accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_round   = r_round;
        n_widx    = r_widx;
        n_closing = r_closing;
        o_cmd     = '0;
        o_cmd.round_idx = r_round;
        o_cmd.word_idx  = r_widx;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load_in = i_has_byte;
                    if (i_is_last) begin
                        n_closing = 1'b1;
                    end
                    if (i_has_byte && i_sts.pos_last) begin
                        o_cmd.start = 1'b1;
                        n_round     = '0;
                        n_state     = S_COMP;
                    end else if (i_is_last) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                o_cmd.load_pad = 1'b1;
                if (i_sts.pos_last) begin
                    o_cmd.start = 1'b1;
                    n_round     = '0;
                    n_state     = S_COMP;
                end
            end
            S_COMP: begin
                o_cmd.round = 1'b1;
                n_round     = r_round + 1'b1;
                if (r_round == ROUND_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                if (!r_closing) begin
                    n_state = S_IDLE;
                end else if (i_sts.final_blk) begin
                    n_widx  = '0;
                    n_state = S_OUT;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_widx     = r_widx + 1'b1;
                    if (r_widx == WIDX_LAST) begin
                        // digest word copied out, rearm for the next message
                        o_cmd.clear = 1'b1;
                        n_closing   = 1'b0;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_round   <= '0;
            r_widx    <= '0;
            r_closing <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_round   <= n_round;
            r_widx    <= n_widx;
            r_closing <= n_closing;
        end
    end

`include "sha256_stream_hasher_macros.svh"

    `SHA_ASSERT_SAME(a_emit_free, i_clk, i_rst_n, o_cmd.emit, i_sts.out_free, "emit into a full output stage")
    `SHA_ASSERT_NEXT(a_start_round0, i_clk, i_rst_n, o_cmd.start, (r_state == S_COMP) && (r_round == '0), "compression did not start at round zero")
    `SHA_ASSERT_NEXT(a_out_done, i_clk, i_rst_n, o_cmd.emit && (o_cmd.word_idx == WIDX_LAST), (r_state == S_IDLE) && !r_closing, "not idle after the last digest word")

endmodule

// ===== rtl/sha256_dp.sv =====
// datapath of the sha256 stream hasher: block window, message schedule, round logic,
// hash state, length counter and output stage; depends on sha256_pkg and the macros header
module sha256_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_data_byte,
    input  sha256_pkg::t_cmd  i_cmd,
    output sha256_pkg::t_sts  o_sts,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [31:0]       o_digest_word,
    output logic [2:0]        o_word_index,
    output logic              o_last_word
);
    import sha256_pkg::*;

    localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(BLK_BYTES - 1);
    localparam logic [WIDX_W-1:0] WIDX_LAST = WIDX_W'(WORDS - 1);

    // block window: schedule word i sits at bits [BLK_BITS-1-32*i -: 32]
    logic [BLK_BITS-1:0] r_blk;
    logic [31:0]         r_v [WORDS];
    logic [31:0]         r_h [WORDS];
    logic [COUNT_W-1:0]  r_byte_count;
    logic [POS_W-1:0]    r_pos;
    logic                r_mark;
    logic                r_final;
    logic                r_ovld;
    logic [31:0]         r_oword;
    logic [WIDX_W-1:0]   r_oidx;
    logic                r_olast;

    logic [31:0] w0, w1, w9, w14, w_new;
    logic [31:0] s1, ch, t1, s0, mj, t2;
    logic [63:0] len_bits;
    logic [2:0]  len_sel;
    logic [7:0]  len_byte;
    logic [7:0]  pad_byte;
    logic [7:0]  shift_byte;
    logic        in_len_field;

    assign w0  = r_blk[BLK_BITS-1 -: 32];
    assign w1  = r_blk[BLK_BITS-1-32*1 -: 32];
    assign w9  = r_blk[BLK_BITS-1-32*9 -: 32];
    assign w14 = r_blk[BLK_BITS-1-32*14 -: 32];
    assign w_new = sml_sig1(w14) + w9 + sml_sig0(w1) + w0;

    always_comb begin
        s1 = big_sig1(r_v[4]);
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1 = r_v[7] + s1 + ch + K_TABLE[i_cmd.round_idx] + w0;
        s0 = big_sig0(r_v[0]);
        mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2 = s0 + mj;
    end

    // length field: big-endian bit count in the last eight bytes of the final block
    assign len_bits     = {r_byte_count, 3'b000};
    assign len_sel      = 3'd7 - r_pos[2:0];
    assign len_byte     = len_bits[{len_sel, 3'b000} +: 8];
    assign in_len_field = (r_pos[POS_W-1:3] == 3'b111);

    always_comb begin
        if (!r_mark) begin
            pad_byte = PAD_MARK;
        end else if (r_final && in_len_field) begin
            pad_byte = len_byte;
        end else begin
            pad_byte = 8'h00;
        end
    end

    assign shift_byte = i_cmd.load_pad ? pad_byte : i_data_byte;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in || i_cmd.load_pad) begin
            r_blk <= {r_blk[BLK_BITS-9:0], shift_byte};
        end else if (i_cmd.round) begin
            r_blk <= {r_blk[BLK_BITS-33:0], w_new};
        end
        if (i_cmd.start) begin
            r_v <= r_h;
        end else if (i_cmd.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
        if (i_cmd.emit) begin
            r_oword <= r_h[i_cmd.word_idx];
            r_oidx  <= i_cmd.word_idx;
            r_olast <= (i_cmd.word_idx == WIDX_LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h          <= IV_TABLE;
            r_byte_count <= '0;
            r_pos        <= '0;
            r_mark       <= 1'b0;
            r_final      <= 1'b0;
            r_ovld       <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_h <= IV_TABLE;
            end else if (i_cmd.finish) begin
                for (int i = 0; i < WORDS; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end
            if (i_cmd.clear) begin
                r_byte_count <= '0;
            end else if (i_cmd.load_in) begin
                r_byte_count <= r_byte_count + 1'b1;
            end
            if (i_cmd.load_in || i_cmd.load_pad) begin
                r_pos <= r_pos + 1'b1;
            end
            if (i_cmd.clear) begin
                r_mark  <= 1'b0;
                r_final <= 1'b0;
            end else if (i_cmd.load_pad) begin
                if (!r_mark) begin
                    r_mark <= 1'b1;
                    // marker leaves room for the length in this block
                    if (!in_len_field) begin
                        r_final <= 1'b1;
                    end
                end else if (r_pos == '0) begin
                    // second padding block after the marker overflowed
                    r_final <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_ovld <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    assign o_sts.pos_last  = (r_pos == POS_LAST);
    assign o_sts.final_blk = r_final;
    assign o_sts.out_free  = !r_ovld || !i_out_stall;

    assign o_out_valid   = r_ovld;
    assign o_digest_word = r_oword;
    assign o_word_index  = r_oidx;
    assign o_last_word   = r_olast;

`include "sha256_stream_hasher_macros.svh"

    `SHA_ASSERT_SAME(a_one_loader, i_clk, i_rst_n, i_cmd.load_pad, !i_cmd.load_in, "pad and message byte loaded together")
    `SHA_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, i_cmd.load_in && !i_cmd.clear, r_byte_count == $past(r_byte_count) + 1'b1, "byte count did not advance")
    `SHA_ASSERT_NEXT(a_clear_state, i_clk, i_rst_n, i_cmd.clear, (r_byte_count == '0) && (r_pos == '0) && !r_mark && (r_h[0] == IV_TABLE[0]), "hasher not rearmed after digest")

endmodule

// ===== rtl/sha256_stream_hasher.sv =====
// SHA-256 stream hasher: one message byte per input item, is_last closes the message
// (an item without a byte may close it), and eight digest words come out, word 0 first.
// Message bytes are taken while the controller is idle; every 64th byte starts a 64-round
// compression that runs one round per cycle and then folds into the hash, with the input
// stalled during the compression and the fold. Closing a message shifts in the padding one
// byte per cycle up to the block end (one or two blocks, each followed by its compression),
// then emits the eight words at one per cycle while the output is not stalled, through an
// output register; the next message may start while word 7 waits.
// depends on sha256_pkg, sha256_ctrl and sha256_dp
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_is_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha256_pkg::*;

    t_cmd cmd;
    t_sts sts;

    sha256_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_has_byte (i_has_byte),
        .i_is_last  (i_is_last),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sha256_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (i_data_byte),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule
